// ----- hw/rtl/drlpe_pkg.sv -----
// types and constants shared by the delta run-length pixel encoder
// no dependencies; compiled before every other file of the block
`default_nettype none

package drlpe_pkg;

    localparam int CHAN_W   = 16;
    localparam int NUM_CHAN = 4;
    localparam int COUNT_W  = 4;
    localparam int DIFF_W   = 13;
    localparam int HI_W     = 3;
    localparam int CHUNK_W  = COUNT_W + NUM_CHAN * DIFF_W;
    localparam int EXT_W    = COUNT_W + NUM_CHAN * HI_W;

    localparam logic [COUNT_W-1:0]  RUN_MAX     = 4'd15;
    localparam logic [COUNT_W-1:0]  COUNT_NONE  = 4'd0;
    localparam logic [COUNT_W-1:0]  COUNT_FIRST = 4'd1;
    localparam logic [CHAN_W-1:0]   SIGN_FLIP   = 16'h8000;
    localparam logic [CHAN_W:0]     HALF_RANGE  = 17'd4096;
    localparam logic [HI_W-1:0]     HI_OFFSET   = 3'd4;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int LEVEL_W    = 3;

    // red in the low bits, opacity in the high bits
    typedef struct packed {
        logic [CHAN_W-1:0] opacity;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        pixel_t             color;
        pixel_t             prior;
        logic [COUNT_W-1:0] count;
        logic               eos;
    } run_req_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_word;
        logic [EXT_W-1:0]   extension_word;
        logic               has_extension;
        logic               end_of_stream;
    } code_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               has_room;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/drlpe_pixel_if.sv -----
// pixel input channel: valid/ready handshake with one rgba pixel per beat
// depends on drlpe_pkg for the channel width
`default_nettype none

interface drlpe_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [drlpe_pkg::CHAN_W-1:0] red;
    logic [drlpe_pkg::CHAN_W-1:0] green;
    logic [drlpe_pkg::CHAN_W-1:0] blue;
    logic [drlpe_pkg::CHAN_W-1:0] opacity;
    logic                         last_pixel;

    modport source (
        output valid, red, green, blue, opacity, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, opacity, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/drlpe_code_if.sv -----
// code output channel: valid/ready handshake with one chunk per beat
// depends on drlpe_pkg for the field widths
`default_nettype none

interface drlpe_code_if;
    logic                          valid;
    logic                          ready;
    logic [drlpe_pkg::CHUNK_W-1:0] chunk_word;
    logic [drlpe_pkg::EXT_W-1:0]   extension_word;
    logic                          has_extension;
    logic                          end_of_stream;

    modport source (
        output valid, chunk_word, extension_word, has_extension, end_of_stream,
        input  ready
    );

    modport sink (
        input  valid, chunk_word, extension_word, has_extension, end_of_stream,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/drlpe_chunk_pack.sv -----
// turns one closed run into a chunk and optional extension word
// depends on drlpe_pkg for run_req_t and code_t
`default_nettype none

module drlpe_chunk_pack (
    input  drlpe_pkg::run_req_t req,
    output drlpe_pkg::code_t    code
);

    logic [drlpe_pkg::NUM_CHAN-1:0][drlpe_pkg::CHAN_W-1:0] run_ch;
    logic [drlpe_pkg::NUM_CHAN-1:0][drlpe_pkg::CHAN_W-1:0] prior_ch;
    logic [drlpe_pkg::NUM_CHAN-1:0][drlpe_pkg::CHAN_W-1:0] diff;
    logic [drlpe_pkg::NUM_CHAN-1:0][drlpe_pkg::HI_W-1:0]   hi;
    logic [drlpe_pkg::NUM_CHAN-1:0][drlpe_pkg::DIFF_W-1:0] lo;
    logic                                                  ext_needed;

    assign run_ch   = req.color;
    assign prior_ch = req.prior;

    for (genvar k = 0; k < drlpe_pkg::NUM_CHAN; k++) begin : g_chan
        logic [drlpe_pkg::CHAN_W:0] biased_sum;

        // wrapping difference, then the signed high part via a biased add
        assign diff[k]     = run_ch[k] - prior_ch[k];
        assign biased_sum  = {1'b0, diff[k] ^ drlpe_pkg::SIGN_FLIP} + drlpe_pkg::HALF_RANGE;
        assign hi[k]       = biased_sum[drlpe_pkg::CHAN_W-1:drlpe_pkg::DIFF_W]
                           + drlpe_pkg::HI_OFFSET;
        assign lo[k]       = diff[k][drlpe_pkg::DIFF_W-1:0];
    end

    assign ext_needed = |hi;

    always_comb
    begin
        code.chunk_word     = {lo, (ext_needed ? drlpe_pkg::COUNT_NONE : req.count)};
        code.extension_word = ext_needed ? {hi, req.count} : '0;
        code.has_extension  = ext_needed;
        code.end_of_stream  = req.eos;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/drlpe_run_tracker.sv -----
// run state: open run colour and count, previous run colour
// depends on drlpe_pkg; yields up to two run requests per pixel
`default_nettype none

module drlpe_run_tracker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step,
    input  drlpe_pkg::pixel_t                    pix,
    input  wire logic                            last,
    output drlpe_pkg::run_req_t                  req0,
    output drlpe_pkg::run_req_t                  req1,
    output logic [1:0]                           req_num,
    output logic [drlpe_pkg::COUNT_W-1:0]        open_count
);

    drlpe_pkg::pixel_t             prior_reg, prior_next;
    drlpe_pkg::pixel_t             color_reg, color_next;
    logic [drlpe_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                          extend;
    logic                          close_open;
    drlpe_pkg::pixel_t             run_color;
    drlpe_pkg::pixel_t             run_prior;
    logic [drlpe_pkg::COUNT_W-1:0] run_count;
    drlpe_pkg::run_req_t           req_close;
    drlpe_pkg::run_req_t           req_flush;

    always_comb
    begin
        extend     = (count_reg != drlpe_pkg::COUNT_NONE) && (pix == color_reg)
                   && (count_reg < drlpe_pkg::RUN_MAX);
        close_open = !extend && (count_reg != drlpe_pkg::COUNT_NONE);

        run_color  = extend ? color_reg : pix;
        run_count  = extend ? count_reg + drlpe_pkg::COUNT_FIRST : drlpe_pkg::COUNT_FIRST;
        run_prior  = close_open ? color_reg : prior_reg;

        req_close.color = color_reg;
        req_close.prior = prior_reg;
        req_close.count = count_reg;
        req_close.eos   = 1'b0;

        req_flush.color = run_color;
        req_flush.prior = run_prior;
        req_flush.count = run_count;
        req_flush.eos   = 1'b1;

        req0    = close_open ? req_close : req_flush;
        req1    = req_flush;
        req_num = {1'b0, close_open} + {1'b0, last};

        if (last)
        begin
            prior_next = '0;
            color_next = '0;
            count_next = drlpe_pkg::COUNT_NONE;
        end
        else
        begin
            prior_next = run_prior;
            color_next = run_color;
            count_next = run_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= '0;
            color_reg <= '0;
            count_reg <= drlpe_pkg::COUNT_NONE;
        end
        else if (step)
        begin
            prior_reg <= prior_next;
            color_reg <= color_next;
            count_reg <= count_next;
        end
    end

    assign open_count = count_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/drlpe_result_fifo.sv -----
// small result queue taking up to two codes per cycle, giving one per beat
// depends on drlpe_pkg for code_t and the queue sizes
`default_nettype none

module drlpe_result_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_num,
    input  drlpe_pkg::code_t       push0,
    input  drlpe_pkg::code_t       push1,
    input  wire logic              pop,
    output logic                   head_valid,
    output drlpe_pkg::code_t       head,
    output drlpe_pkg::fifo_stat_t  stat
);

    drlpe_pkg::code_t                  mem [drlpe_pkg::FIFO_DEPTH];
    logic [drlpe_pkg::PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [drlpe_pkg::PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [drlpe_pkg::LEVEL_W-1:0]     level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + drlpe_pkg::PTR_W'(push_num);
        rd_ptr_next = rd_ptr_reg + drlpe_pkg::PTR_W'(pop);
        level_next  = level_reg + drlpe_pkg::LEVEL_W'(push_num)
                    - drlpe_pkg::LEVEL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_num == 2'd2)
        begin
            mem[wr_ptr_reg + drlpe_pkg::PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head_valid    = (level_reg != '0);
    assign head          = mem[rd_ptr_reg];
    assign stat.level    = level_reg;
    assign stat.has_room = (level_reg <= drlpe_pkg::LEVEL_W'(drlpe_pkg::FIFO_DEPTH - 2));

endmodule

`default_nettype wire

// ----- hw/rtl/delta_run_length_pixel_encoder_unit.sv -----
// Delta run-length pixel encoder, top level. Pixels arrive as beats on pixel_in; equal
// pixels gather into runs of up to 15, and each closed run leaves on code_out as a 56-bit
// chunk of count plus four 13-bit colour deltas against the previous run, with a 16-bit
// extension word when any delta falls outside -4096..4095 (the chunk count is then 0).
// A last_pixel beat flushes the open run with end_of_stream set and returns all run state
// to zero, so the next beat starts a new image. One pixel is taken per clock while the
// queue has room; a pixel goes through an input register, then through the run tracker
// and the chunk packers into a four-entry result queue. A pixel that closes a run and is
// also the last pixel yields two codes, and the single-code-per-beat output port then
// sets the rate: the queue needs room for two codes before the next pixel moves out of
// the input register. The output may stall for any length without loss; the input keeps
// flowing as long as the queue has room.
// depends on drlpe_pkg, drlpe_pixel_if, drlpe_code_if and the drlpe submodules
`default_nettype none

module delta_run_length_pixel_encoder_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    drlpe_pixel_if.sink   pixel_in,
    drlpe_code_if.source  code_out
);

    // input register stage
    logic                          full_reg, full_next;
    drlpe_pkg::pixel_t             pix_reg;
    logic                          last_reg;

    // processing and queue
    logic                          step;
    logic                          in_beat;
    drlpe_pkg::run_req_t           req0;
    drlpe_pkg::run_req_t           req1;
    logic [1:0]                    req_num;
    logic [drlpe_pkg::COUNT_W-1:0] open_count;
    drlpe_pkg::code_t              code0;
    drlpe_pkg::code_t              code1;
    drlpe_pkg::code_t              head;
    logic                          head_valid;
    drlpe_pkg::fifo_stat_t         fifo_stat;

    // the registered pixel moves on once the queue can take two codes
    assign step    = full_reg && fifo_stat.has_room;
    assign in_beat = pixel_in.valid && pixel_in.ready;

    assign pixel_in.ready = !full_reg || step;

    always_comb
    begin
        full_next = full_reg;
        if (in_beat)
        begin
            full_next = 1'b1;
        end
        else if (step)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // pixel payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            pix_reg.red     <= pixel_in.red;
            pix_reg.green   <= pixel_in.green;
            pix_reg.blue    <= pixel_in.blue;
            pix_reg.opacity <= pixel_in.opacity;
            last_reg        <= pixel_in.last_pixel;
        end
    end

    // run bookkeeping: closing run first, flushed run second
    drlpe_run_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pix        (pix_reg),
        .last       (last_reg),
        .req0       (req0),
        .req1       (req1),
        .req_num    (req_num),
        .open_count (open_count)
    );

    drlpe_chunk_pack u_pack0 (
        .req  (req0),
        .code (code0)
    );

    drlpe_chunk_pack u_pack1 (
        .req  (req1),
        .code (code1)
    );

    drlpe_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_num   (step ? req_num : 2'd0),
        .push0      (code0),
        .push1      (code1),
        .pop        (code_out.valid && code_out.ready),
        .head_valid (head_valid),
        .head       (head),
        .stat       (fifo_stat)
    );

    assign code_out.valid          = head_valid;
    assign code_out.chunk_word     = head.chunk_word;
    assign code_out.extension_word = head.extension_word;
    assign code_out.has_extension  = head.has_extension;
    assign code_out.end_of_stream  = head.end_of_stream;

`ifndef SYNTH
    // queue never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.level <= drlpe_pkg::LEVEL_W'(drlpe_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // a flushed image leaves no run open
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_reg |=> open_count == drlpe_pkg::COUNT_NONE)
        else $error("run still open after last pixel");

    // an extended chunk carries its count in the extension word only
    a_ext_count: assert property (@(posedge clk) disable iff (!rst_n)
        code_out.valid && code_out.has_extension
            |-> code_out.chunk_word[drlpe_pkg::COUNT_W-1:0] == drlpe_pkg::COUNT_NONE
             && code_out.extension_word[drlpe_pkg::COUNT_W-1:0] != drlpe_pkg::COUNT_NONE)
        else $error("count placed wrongly in extended chunk");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench for the delta run-length pixel encoder: directed table then random images
// depends on drlpe_pkg, drlpe_pixel_if, drlpe_code_if and the encoder top level

module tb;
    import drlpe_pkg::*;

    localparam int PLAN_ROWS     = 14;
    localparam int RANDOM_PIXELS = 1120;
    localparam int DRAIN_LIMIT   = 20000;
    localparam code_t NO_CODE    = '0;

    // one row of the directed table: a pixel repeated reps times, last only on the final beat
    typedef struct packed {
        pixel_t         pix;
        logic           last;
        logic [4:0]     reps;
        logic           typed;
        code_t          want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    drlpe_pixel_if pix_ch ();
    drlpe_code_if  code_ch ();

    delta_run_length_pixel_encoder_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pix_ch),
        .code_out (code_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // encoder model state, mirrors the run tracker
    pixel_t             prev_run_colour;
    pixel_t             cur_run_colour;
    logic [COUNT_W-1:0] cur_run_len;

    code_t pending_codes [$];

    int  mismatches;
    int  pixels_sent;
    int  images_sent;
    int  codes_checked;
    int  ext_codes;
    logic src_burst;
    logic snk_burst;

    // pixel (opacity blue green red), last, reps, typed, expected code
    plan_row_t plan [PLAN_ROWS] = '{
        // straight after reset: zero pixel, count one, no deltas
        {64'h0000_0000_0000_0000, 1'b1, 5'd1, 1'b1, {56'h1, 16'h0, 1'b0, 1'b1}},
        {64'h0000_0000_0000_0001, 1'b1, 5'd1, 1'b1, {56'h11, 16'h0, 1'b0, 1'b1}},
        // all ones is a delta of -1 on every channel
        {64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd1, 1'b1, {56'hFFFFFFFFFFFFF1, 16'h0, 1'b0, 1'b1}},
        // edges of the short delta range on red
        {64'h0000_0000_0000_0FFF, 1'b1, 5'd1, 1'b1, {56'hFFF1, 16'h0, 1'b0, 1'b1}},
        {64'h0000_0000_0000_1000, 1'b1, 5'd1, 1'b1, {56'h10000, 16'h11, 1'b1, 1'b1}},
        {64'h0000_0000_0000_F000, 1'b1, 5'd1, 1'b1, {56'h10001, 16'h0, 1'b0, 1'b1}},
        {64'h0000_0000_0000_EFFF, 1'b1, 5'd1, 1'b1, {56'hFFF0, 16'h71, 1'b1, 1'b1}},
        // most negative and most positive deltas, then range edges on green and blue
        {64'h0000_0000_0000_8000, 1'b1, 5'd1, 1'b1, {56'h0, 16'h41, 1'b1, 1'b1}},
        {64'h7FFF_0000_0000_0000, 1'b1, 5'd1, 1'b1, {56'hFFF80000000000, 16'h8001, 1'b1, 1'b1}},
        {64'h0000_0000_1000_0000, 1'b1, 5'd1, 1'b1, {56'h20000000, 16'h81, 1'b1, 1'b1}},
        {64'h0000_EFFF_0000_0000, 1'b1, 5'd1, 1'b1, {56'h3FFC0000000, 16'h1C01, 1'b1, 1'b1}},
        // sixteen equal pixels: the full run closes and a new one opens
        {64'h1234_5678_9ABC_DEF0, 1'b0, 5'd16, 1'b0, NO_CODE},
        // colour change, then a last pixel that also closes a run: two codes
        {64'h1235_5670_9AB0_DEF8, 1'b0, 5'd2, 1'b0, NO_CODE},
        {64'hFFFF_0000_FFFF_0000, 1'b1, 5'd1, 1'b0, NO_CODE}
    };

    // code for one closed run against the colour of the run before it
    function automatic code_t pack_run(input pixel_t colour, input pixel_t base,
                                       input logic [COUNT_W-1:0] len, input logic eos);
        code_t              c;
        logic [CHAN_W-1:0]  delta;
        logic [CHAN_W:0]    biased;
        logic [HI_W-1:0]    hi;
        logic [CHUNK_W-1:0] chunk;
        logic [EXT_W-1:0]   ext;
        chunk = '0;
        ext   = '0;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            delta  = colour[k*CHAN_W +: CHAN_W] - base[k*CHAN_W +: CHAN_W];
            // signed delta shifted up by half the range, then rounded into 8192-wide bins
            biased = {1'b0, delta ^ SIGN_FLIP} + HALF_RANGE;
            hi     = biased[CHAN_W-1:DIFF_W] + HI_OFFSET;
            chunk[COUNT_W + k*DIFF_W +: DIFF_W] = delta[DIFF_W-1:0];
            ext[COUNT_W + k*HI_W +: HI_W]       = hi;
        end
        c.has_extension = (ext != '0);
        chunk[COUNT_W-1:0] = c.has_extension ? COUNT_NONE : len;
        if (c.has_extension)
            ext[COUNT_W-1:0] = len;
        c.chunk_word     = chunk;
        c.extension_word = ext;
        c.end_of_stream  = eos;
        return c;
    endfunction

    // advance the run state by one pixel; returns how many codes it closes
    function automatic int step_encoder(input pixel_t p, input logic last,
                                        output code_t first_code, output code_t second_code);
        int    n;
        code_t c;
        n = 0;
        first_code  = NO_CODE;
        second_code = NO_CODE;
        if (cur_run_len != COUNT_NONE && p == cur_run_colour && cur_run_len < RUN_MAX)
            cur_run_len = cur_run_len + 1'b1;
        else
        begin
            if (cur_run_len != COUNT_NONE)
            begin
                first_code      = pack_run(cur_run_colour, prev_run_colour, cur_run_len, 1'b0);
                prev_run_colour = cur_run_colour;
                n = 1;
            end
            cur_run_colour = p;
            cur_run_len    = COUNT_FIRST;
        end
        if (last)
        begin
            c = pack_run(cur_run_colour, prev_run_colour, cur_run_len, 1'b1);
            if (n == 0)
                first_code = c;
            else
                second_code = c;
            n++;
            prev_run_colour = '0;
            cur_run_colour  = '0;
            cur_run_len     = COUNT_NONE;
        end
        return n;
    endfunction

    // wait before the next beat; bursts with no waiting come and go at random
    function automatic int draw_wait(inout logic burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    // new colour per channel: kept, nudged, near a range edge, random, all 0s/1s or flipped
    function automatic pixel_t next_colour(input pixel_t c);
        pixel_t            p;
        logic [CHAN_W-1:0] ch;
        p = c;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            ch = p[k*CHAN_W +: CHAN_W];
            case ($urandom_range(0, 5))
                0: ch = ch;
                1: ch = ch + CHAN_W'($urandom_range(0, 64)) - CHAN_W'(32);
                2:
                begin
                    ch = ch + CHAN_W'(4095 + $urandom_range(0, 2));
                    if ($urandom_range(0, 1) == 1)
                        ch = ch - CHAN_W'(2 * 4096 + 1);
                end
                3: ch = CHAN_W'($urandom);
                4: ch = $urandom_range(0, 1) ? '1 : '0;
                default: ch = ch + ($urandom_range(0, 1) ? SIGN_FLIP : SIGN_FLIP - 1'b1);
            endcase
            p[k*CHAN_W +: CHAN_W] = ch;
        end
        return p;
    endfunction

    task automatic send_pixel(input pixel_t p, input logic last, input logic typed,
                              input code_t want);
        int    gap;
        int    n;
        code_t c0;
        code_t c1;
        gap = draw_wait(src_burst);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.red        <= p.red;
        pix_ch.green      <= p.green;
        pix_ch.blue       <= p.blue;
        pix_ch.opacity    <= p.opacity;
        pix_ch.last_pixel <= last;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        // beat taken at this edge
        n = step_encoder(p, last, c0, c1);
        if (typed)
            pending_codes.push_back(want);
        else
        begin
            if (n > 0)
                pending_codes.push_back(c0);
            if (n > 1)
                pending_codes.push_back(c1);
        end
        pixels_sent++;
        if (last)
            images_sent++;
    endtask

    // output side: ready drops for a random wait before each code, save in bursts with no waiting
    initial
    begin
        int gap;
        code_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_wait(snk_burst);
            if (gap > 0)
            begin
                code_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            code_ch.ready <= 1'b1;
            @(posedge clk);
            while (!code_ch.valid)
                @(posedge clk);
        end
    end

    // every code beat is checked against the oldest expectation
    always @(posedge clk)
    begin
        code_t want;
        if (rst_n && code_ch.valid && code_ch.ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected code chunk %h ext %h has_ext %b eos %b", $time,
                         code_ch.chunk_word, code_ch.extension_word, code_ch.has_extension,
                         code_ch.end_of_stream);
                mismatches++;
            end
            else
            begin
                want = pending_codes.pop_front();
                codes_checked++;
                if (want.has_extension)
                    ext_codes++;
                if (code_ch.chunk_word !== want.chunk_word)
                begin
                    $display("%0t: chunk_word expected %h actual %h", $time,
                             want.chunk_word, code_ch.chunk_word);
                    mismatches++;
                end
                if (code_ch.extension_word !== want.extension_word)
                begin
                    $display("%0t: extension_word expected %h actual %h", $time,
                             want.extension_word, code_ch.extension_word);
                    mismatches++;
                end
                if (code_ch.has_extension !== want.has_extension)
                begin
                    $display("%0t: has_extension expected %b actual %b", $time,
                             want.has_extension, code_ch.has_extension);
                    mismatches++;
                end
                if (code_ch.end_of_stream !== want.end_of_stream)
                begin
                    $display("%0t: end_of_stream expected %b actual %b", $time,
                             want.end_of_stream, code_ch.end_of_stream);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        pixel_t colour;
        pixel_t p;
        int     run_len;
        int     image_left;
        int     random_sent;
        int     drain;
        logic   last;

        mismatches      = 0;
        pixels_sent     = 0;
        images_sent     = 0;
        codes_checked   = 0;
        ext_codes       = 0;
        src_burst       = 1'b0;
        snk_burst       = 1'b0;
        prev_run_colour = '0;
        cur_run_colour  = '0;
        cur_run_len     = COUNT_NONE;

        rst_n             <= 1'b0;
        pix_ch.valid      <= 1'b0;
        pix_ch.red        <= '0;
        pix_ch.green      <= '0;
        pix_ch.blue       <= '0;
        pix_ch.opacity    <= '0;
        pix_ch.last_pixel <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PLAN_ROWS; r++)
            for (int i = 1; i <= plan[r].reps; i++)
                send_pixel(plan[r].pix, plan[r].last && (i == plan[r].reps), plan[r].typed,
                           plan[r].want);

        // random images: mostly runs of related colours, some stray pixels
        colour      = '0;
        image_left  = $urandom_range(1, 60);
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                p = {$urandom, $urandom};
                send_pixel(p, $urandom_range(0, 7) == 0, 1'b0, NO_CODE);
                random_sent++;
            end
            else
            begin
                // now and then a run long enough to fill up
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 17)
                                                      : $urandom_range(1, 5);
                colour = next_colour(colour);
                for (int i = 0; i < run_len; i++)
                begin
                    image_left--;
                    last = (image_left == 0);
                    if (last)
                        image_left = $urandom_range(1, 60);
                    send_pixel(colour, last, 1'b0, NO_CODE);
                    random_sent++;
                end
            end
        end
        pix_ch.valid <= 1'b0;

        drain = 0;
        while (pending_codes.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_codes.size() != 0)
        begin
            $display("%0t: %0d expected codes never arrived", $time, pending_codes.size());
            mismatches += pending_codes.size();
        end
        // room for any stray code still in flight
        repeat (20) @(posedge clk);

        $display("%0d pixels in %0d closed images, %0d codes compared (%0d with extension)",
                 pixels_sent, images_sent, codes_checked, ext_codes);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
